[rtl/image_convolution_3x3_unit_defines.svh]
// assertion helpers used by the checker file
`ifndef IMAGE_CONVOLUTION_3X3_UNIT_DEFINES_SVH
`define IMAGE_CONVOLUTION_3X3_UNIT_DEFINES_SVH

// property checked on every clock edge outside of reset
`define ICU_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("icu check failed");

// property checked on every clock edge, reset included
`define ICU_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("icu check failed");

`endif

[rtl/icu_pkg.sv]
package icu_pkg;

	// sizes
	localparam int MAX_WIDTH      = 4096;
	localparam int COEF_FRAC_BITS = 8;
	localparam int ADDR_W         = $clog2(MAX_WIDTH);
	localparam int CNT_W          = 13;
	localparam int DIM_W          = CNT_W + 1;
	localparam int PIX_W          = 8;
	localparam int COEF_W         = 16;
	localparam int KROW_W         = 3 * COEF_W;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = KROW_W;
	localparam int PROD_W         = COEF_W + PIX_W;
	localparam int RSUM_W         = PROD_W + 2;
	localparam int SUM_W          = RSUM_W + 2;
	localparam int MIN_DIM        = 3;

	// rounding constants
	localparam logic [SUM_W-1:0] FRAC_MASK = (SUM_W'(1) << COEF_FRAC_BITS) - SUM_W'(1);
	localparam logic [SUM_W-1:0] FRAC_HALF = (SUM_W'(1) << COEF_FRAC_BITS) >> 1;
	localparam logic [SUM_W-1:0] PIX_MAX   = SUM_W'((1 << PIX_W) - 1);

	// register reset values
	localparam logic [KROW_W-1:0] KERNEL_TOP_RST    = 48'h0100_0000_ff00;
	localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RST = 48'h0200_0000_fe00;
	localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RST = 48'h0100_0000_ff00;
	localparam logic [CNT_W-1:0]  IMAGE_WIDTH_RST   = CNT_W'(512);
	localparam logic [CNT_W-1:0]  IMAGE_HEIGHT_RST  = CNT_W'(512);

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KERNEL_TOP    = 3'd0,
		CFG_KERNEL_MIDDLE = 3'd1,
		CFG_KERNEL_BOTTOM = 3'd2,
		CFG_IMAGE_WIDTH   = 3'd3,
		CFG_IMAGE_HEIGHT  = 3'd4,
		CFG_BORDER_MODE   = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		FUNC_PIXEL = 1'b0,
		FUNC_FLUSH = 1'b1
	} func_t;

	// one signed coefficient out of a packed kernel row
	function automatic logic signed [COEF_W-1:0] coef_of(input logic [KROW_W-1:0] row,
			input logic [1:0] col);
		return row[COEF_W*col +: COEF_W];
	endfunction

	// round half to even, then clamp to the pixel range
	function automatic pix_t round_sat(input logic signed [SUM_W-1:0] sum);
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] q;
		logic [SUM_W-1:0] rem;
		logic             up;
		s   = sum;
		q   = s >> COEF_FRAC_BITS;
		rem = s & FRAC_MASK;
		up  = (COEF_FRAC_BITS != 0) && (rem > FRAC_HALF || (rem == FRAC_HALF && q[0]));
		q   = q + SUM_W'(up);
		if (sum <= 0)
			return '0;
		if (q > PIX_MAX)
			return '1;
		return q[PIX_W-1:0];
	endfunction

endpackage

[rtl/icu_if.sv]
// pixel request channel
interface icu_pix_if import icu_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       func;
	pix_t       pixel_value;

	modport source (output valid, output func, output pixel_value, input ready);
	modport sink (input valid, input func, input pixel_value, output ready);
endinterface

// result channel
interface icu_res_if import icu_pkg::*; ();
	logic       valid;
	logic       ready;
	pix_t       out_pixel;
	logic       out_last;

	modport source (output valid, output out_pixel, output out_last, input ready);
	modport sink (input valid, input out_pixel, input out_last, output ready);
endinterface

// register write channel
interface icu_cfg_if import icu_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/image_convolution_3x3_unit.sv]
// 3x3 convolution over a raster pixel stream, two line-buffer memories plus a window.
// Throughput: one request per cycle, held back only while a result in the output register is refused.
// The request that completes a result passes through memory read, window shift, multiply,
// row sums and round before it leaves the output register; results trail the stream by W+1.
// Reset (arst_n low, asynchronous): counters, window and valids clear, registers take defaults;
// the line memories are not cleared, their stale entries are masked at image borders.
module image_convolution_3x3_unit import icu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	icu_pix_if.sink   pixels,
	icu_res_if.source results,
	icu_cfg_if.sink   cfg
);

	// configuration registers
	logic [KROW_W-1:0] kernel_q [3];
	logic [CNT_W-1:0]  width_q;
	logic [CNT_W-1:0]  height_q;
	logic              border_q;

	// frame position counters
	logic [CNT_W-1:0] in_col_q, in_row_q, out_col_q, out_row_q;
	logic [CNT_W-1:0] in_col_n, in_row_n, out_col_n, out_row_n;

	// line memories and their registered read data
	pix_t top_mem [MAX_WIDTH];
	pix_t mid_mem [MAX_WIDTH];
	pix_t rd_top_q, rd_mid_q;

	// pipeline
	logic              valid_s1, mask_s1, wr_en_s1, emit_s1, last_s1;
	logic [ADDR_W-1:0] addr_s1;
	pix_t              pix_s1;
	logic [8:0]        cell_en_s1;
	logic              valid_s2, last_s2;
	logic [8:0]        cell_en_s2;
	logic              valid_s3, last_s3;
	logic signed [PROD_W-1:0] prod_s3 [9];
	logic              valid_s4, last_s4;
	logic signed [RSUM_W-1:0] rsum_s4 [3];
	pix_t              window_q [3][3];
	logic              out_valid_q, out_last_q;
	pix_t              out_pixel_q;

	// stage 0 decode
	logic [DIM_W-1:0] w_eff, h_eff, col_inc, ocol_inc, orow_inc;
	logic             draining, dropped, advance, acc, take, emit, last;
	logic             col_ok_mem;
	logic [2:0]       row_ok, col_ok;
	logic             ring_zero;
	logic [8:0]       cell_en;
	pix_t             top_px, mid_px;
	logic signed [SUM_W-1:0] total;

	// register writes, always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0] <= KERNEL_TOP_RST;
			kernel_q[1] <= KERNEL_MIDDLE_RST;
			kernel_q[2] <= KERNEL_BOTTOM_RST;
			width_q     <= IMAGE_WIDTH_RST;
			height_q    <= IMAGE_HEIGHT_RST;
			border_q    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				CFG_KERNEL_TOP:    kernel_q[0] <= cfg.data[KROW_W-1:0];
				CFG_KERNEL_MIDDLE: kernel_q[1] <= cfg.data[KROW_W-1:0];
				CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg.data[KROW_W-1:0];
				CFG_IMAGE_WIDTH:   width_q     <= cfg.data[CNT_W-1:0];
				CFG_IMAGE_HEIGHT:  height_q    <= cfg.data[CNT_W-1:0];
				CFG_BORDER_MODE:   border_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// clamped image size
	always_comb begin
		if (width_q < CNT_W'(MIN_DIM))
			w_eff = DIM_W'(MIN_DIM);
		else if ({1'b0, width_q} > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		else
			w_eff = {1'b0, width_q};
		if (height_q < CNT_W'(MIN_DIM))
			h_eff = DIM_W'(MIN_DIM);
		else
			h_eff = {1'b0, height_q};
	end

	// handshake: the whole pipe moves unless a result waits in the output register
	assign advance      = !(out_valid_q && !results.ready);
	assign pixels.ready = advance;
	assign acc          = pixels.valid && advance;
	assign draining     = {1'b0, in_row_q} >= h_eff;
	assign dropped      = !draining && (pixels.func == FUNC_FLUSH);
	assign take         = acc && !dropped;

	// request classification
	assign col_ok_mem = ({1'b0, in_col_q} < w_eff) && ({1'b0, in_col_q} < DIM_W'(MAX_WIDTH));
	assign emit       = draining || (in_row_q >= CNT_W'(2))
		|| (in_row_q == CNT_W'(1) && in_col_q != '0);
	assign col_inc    = {1'b0, in_col_q} + DIM_W'(1);
	assign ocol_inc   = {1'b0, out_col_q} + DIM_W'(1);
	assign orow_inc   = {1'b0, out_row_q} + DIM_W'(1);
	assign last       = (orow_inc >= h_eff) && (ocol_inc >= w_eff);

	// which window cells lie inside the image for the result being formed
	assign row_ok[0] = orow_inc < h_eff;
	assign row_ok[1] = {1'b0, out_row_q} < h_eff;
	assign row_ok[2] = out_row_q != '0;
	assign col_ok[0] = ocol_inc < w_eff;
	assign col_ok[1] = {1'b0, out_col_q} < w_eff;
	assign col_ok[2] = out_col_q != '0;
	assign ring_zero = !border_q && (!row_ok[0] || !row_ok[2] || !col_ok[0] || !col_ok[2]);

	always_comb begin
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				cell_en[a*3+b] = row_ok[a] && col_ok[b] && !ring_zero;
	end

	// next counter values
	always_comb begin
		in_col_n  = in_col_q;
		in_row_n  = in_row_q;
		out_col_n = out_col_q;
		out_row_n = out_row_q;
		if (!draining) begin
			if (col_inc >= w_eff) begin
				in_col_n = '0;
				in_row_n = in_row_q + CNT_W'(1);
			end else begin
				in_col_n = col_inc[CNT_W-1:0];
			end
		end else if (in_col_q != '1) begin
			in_col_n = in_col_q + CNT_W'(1);
		end
		if (emit) begin
			if (last) begin
				in_col_n  = '0;
				in_row_n  = '0;
				out_col_n = '0;
				out_row_n = '0;
			end else if (ocol_inc >= w_eff) begin
				out_col_n = '0;
				out_row_n = out_row_q + CNT_W'(1);
			end else begin
				out_col_n = ocol_inc[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			in_col_q  <= in_col_n;
			in_row_q  <= in_row_n;
			out_col_q <= out_col_n;
			out_row_q <= out_row_n;
		end
	end

	// line memories: read on request, write back from stage s1 when the pipe advances
	always_ff @(posedge clk) begin
		if (take) begin
			rd_top_q <= top_mem[in_col_q[ADDR_W-1:0]];
			rd_mid_q <= mid_mem[in_col_q[ADDR_W-1:0]];
		end
		if (advance && valid_s1 && wr_en_s1) begin
			top_mem[addr_s1] <= mid_px;
			mid_mem[addr_s1] <= pix_s1;
		end
	end

	// masked memory data for the new window column
	assign top_px = mask_s1 ? rd_top_q : '0;
	assign mid_px = mask_s1 ? rd_mid_q : '0;

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= take;
			valid_s2    <= valid_s1 && emit_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// window shift, once per request that is not dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					window_q[i][j] <= '0;
		end else if (advance && valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				window_q[i][0] <= window_q[i][1];
				window_q[i][1] <= window_q[i][2];
			end
			window_q[0][2] <= top_px;
			window_q[1][2] <= mid_px;
			window_q[2][2] <= pix_s1;
		end
	end

	// total of the three row sums
	assign total = SUM_W'(rsum_s4[0]) + SUM_W'(rsum_s4[1]) + SUM_W'(rsum_s4[2]);

	// pipeline payload
	always_ff @(posedge clk) begin
		if (advance) begin
			// s1: request decode
			mask_s1    <= col_ok_mem;
			wr_en_s1   <= !draining && ({1'b0, in_col_q} < DIM_W'(MAX_WIDTH));
			addr_s1    <= in_col_q[ADDR_W-1:0];
			pix_s1     <= draining ? '0 : pixels.pixel_value;
			emit_s1    <= emit;
			last_s1    <= emit && last;
			cell_en_s1 <= cell_en;
			// s2: window settles
			cell_en_s2 <= cell_en_s1;
			last_s2    <= last_s1;
			// s3: flipped kernel products
			for (int a = 0; a < 3; a++)
				for (int b = 0; b < 3; b++)
					prod_s3[a*3+b] <= cell_en_s2[a*3+b]
						? PROD_W'(coef_of(kernel_q[a], 2'(b)))
							* PROD_W'($signed({1'b0, window_q[2-a][2-b]}))
						: '0;
			last_s3 <= last_s2;
			// s4: per row sums
			for (int a = 0; a < 3; a++)
				rsum_s4[a] <= RSUM_W'(prod_s3[a*3]) + RSUM_W'(prod_s3[a*3+1])
					+ RSUM_W'(prod_s3[a*3+2]);
			last_s4 <= last_s3;
			// output register
			out_pixel_q <= round_sat(total);
			out_last_q  <= last_s4;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_pixel = out_pixel_q;
	assign results.out_last  = out_last_q;

endmodule

[rtl/icu_checker.sv]
`include "image_convolution_3x3_unit_defines.svh"

module icu_checker import icu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pix_t out_pixel,
	input logic out_last,
	input logic cfg_valid,
	input logic cfg_ready
);

	// a stalled result stays offered
	`ICU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

	// a stalled result keeps its payload
	`ICU_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_last))

	// input is only held back by a full, stalled output register
	`ICU_ASSERT(a_in_free, (!out_valid || out_ready) |-> in_ready)

	// register writes never wait
	`ICU_ASSERT_ALWAYS(a_cfg_ready, cfg_valid |-> cfg_ready)

	// an input request is never refused while the output drains
	`ICU_ASSERT(a_in_flow, in_valid && !in_ready |-> out_valid && !out_ready)

endmodule

bind image_convolution_3x3_unit icu_checker u_icu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_pixel (results.out_pixel),
	.out_last  (results.out_last),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);
